// ===== sv/dqr_pkg.sv =====
// Shared types and constants for the double-ended ring queue.
package dqr_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
  localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_PEEK      = 3'd4
  } op_t;

  // Result flags of one transaction, computed with the index update.
  typedef struct packed {
    logic             accepted;
    logic             is_empty;
    logic             is_full;
    logic [CAP_W-1:0] occupancy;
  } status_t;

endpackage

// ===== sv/dqr_if.sv =====
// Channel interfaces: command, response and capacity configuration.
interface dqr_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [dqr_pkg::OP_W-1:0]         opcode;
  logic signed [dqr_pkg::DATA_W-1:0] value_in;

  modport source (output valid, opcode, value_in, input ready);
  modport sink   (input valid, opcode, value_in, output ready);
endinterface

interface dqr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [dqr_pkg::DATA_W-1:0] front_value;
  logic signed [dqr_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;
  logic [dqr_pkg::CAP_W-1:0]         occupancy;

  modport source (output valid, accepted, front_value, rear_value, is_empty, is_full,
                  occupancy, input ready);
  modport sink   (input valid, accepted, front_value, rear_value, is_empty, is_full,
                  occupancy, output ready);
endinterface

interface dqr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dqr_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/dqr_ram.sv =====
// Ring store: one write port, two registered read ports, write-to-read forwarding.
module dqr_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [dqr_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr_a,
  input  logic [AW-1:0]             rd_addr_b,
  output logic [dqr_pkg::DATA_W-1:0] rd_data_a,
  output logic [dqr_pkg::DATA_W-1:0] rd_data_b
);

  logic [dqr_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dqr_pkg::DATA_W-1:0] q_a;
  logic [dqr_pkg::DATA_W-1:0] q_b;
  logic [dqr_pkg::DATA_W-1:0] wr_data_q;
  logic                       fwd_a;
  logic                       fwd_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Array read returns the old word on a same-cycle hit; the flags pick the new one.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a       <= mem[rd_addr_a];
      q_b       <= mem[rd_addr_b];
      wr_data_q <= wr_data;
      fwd_a     <= wr_en && (wr_addr == rd_addr_a);
      fwd_b     <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  assign rd_data_a = fwd_a ? wr_data_q : q_a;
  assign rd_data_b = fwd_b ? wr_data_q : q_b;

endmodule

// ===== sv/dqr_ctrl.sv =====
// Head/tail/count registers and the per-transaction index update.
module dqr_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [dqr_pkg::OP_W-1:0]   opcode,
  input  logic [dqr_pkg::CAP_W-1:0]  cap_reg,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [AW-1:0]              head_next,
  output logic [AW-1:0]              tail_next,
  output dqr_pkg::status_t           status
);

  localparam int DEPTH_SAT = (DEPTH > 31) ? 31 : DEPTH;

  logic [AW-1:0]             head;
  logic [AW-1:0]             tail;
  logic [dqr_pkg::CAP_W-1:0] count;
  logic [dqr_pkg::CAP_W-1:0] count_next;
  logic [dqr_pkg::CAP_W-1:0] cap;
  logic                      full;
  logic                      empty;
  logic                      ok;
  dqr_pkg::status_t          status_next;

  function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] idx,
                                             input logic [dqr_pkg::CAP_W-1:0] c);
    logic [AW-1:0] r;
    r = (32'(idx) + 32'd1 >= 32'(c)) ? '0 : idx + 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] idx,
                                              input logic [dqr_pkg::CAP_W-1:0] c);
    logic [AW-1:0] r;
    r = (idx == '0) ? AW'(c - 1'b1) : idx - 1'b1;
    return r;
  endfunction

  // Zero acts as one, anything above the built depth acts as the depth.
  always_comb begin
    if (cap_reg == '0) begin
      cap = dqr_pkg::CAP_W'(1);
    end else if (32'(cap_reg) > DEPTH_SAT) begin
      cap = dqr_pkg::CAP_W'(DEPTH_SAT);
    end else begin
      cap = cap_reg;
    end
  end

  assign full  = count >= cap;
  assign empty = count == '0;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = head;
    ok         = 1'b0;
    case (dqr_pkg::op_t'(opcode))
      dqr_pkg::OP_INS_FRONT: begin
        if (!full) begin
          head_next  = step_back(head, cap);
          if (empty) tail_next = head_next;
          wr_en      = fire;
          wr_addr    = head_next;
          count_next = count + 1'b1;
          ok         = 1'b1;
        end
      end
      dqr_pkg::OP_INS_REAR: begin
        if (!full) begin
          tail_next  = step_fwd(tail, cap);
          if (empty) head_next = tail_next;
          wr_en      = fire;
          wr_addr    = tail_next;
          count_next = count + 1'b1;
          ok         = 1'b1;
        end
      end
      dqr_pkg::OP_DEL_FRONT: begin
        if (!empty) begin
          head_next  = step_fwd(head, cap);
          count_next = count - 1'b1;
          ok         = 1'b1;
        end
      end
      dqr_pkg::OP_DEL_REAR: begin
        if (!empty) begin
          tail_next  = step_back(tail, cap);
          count_next = count - 1'b1;
          ok         = 1'b1;
        end
      end
      dqr_pkg::OP_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    status_next.accepted  = ok;
    status_next.is_empty  = count_next == '0;
    status_next.is_full   = count_next >= cap;
    status_next.occupancy = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status <= status_next;
    end
  end

endmodule

// ===== sv/double_ended_ring_queue.sv =====
// Top level of the double-ended ring queue: config register, pipeline and response register.
// Usage:
//   cmd carries one operation per transaction (opcode, value_in): insert at
//   front, insert at rear, remove front, remove rear, peek. rsp returns exactly
//   one transaction per command: accepted, front/rear values after the
//   operation (-1 when empty), is_empty, is_full and occupancy.
//   cfg writes capacity_in_use (ring entries in use); write it only while no
//   command is in flight. cfg.ready is always high.
// Throughput: one command per cycle while rsp is taken. The index update and
//   the memory write/read are issued in the accept cycle; the ring store's
//   registered read data is captured into the response register once it is free.
// Stall: while rsp is held, one finished command waits in the read stage and
//   cmd.ready drops; nothing is lost or repeated.
// Reset: head, tail and count go to zero, capacity to 16, both channels idle.
//   The ring store is not cleared and needs no clearing pass.
module double_ended_ring_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  dqr_cmd_if.sink   cmd,
  dqr_rsp_if.source rsp,
  dqr_cfg_if.sink   cfg
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [dqr_pkg::CAP_W-1:0]  cap_reg;
  logic                       cmd_fire;
  logic                       pend;      // read stage holds a finished command
  logic                       out_load;  // read stage moves into rsp register
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              head_next;
  logic [AW-1:0]              tail_next;
  logic [dqr_pkg::DATA_W-1:0] rd_front;
  logic [dqr_pkg::DATA_W-1:0] rd_rear;
  dqr_pkg::status_t           status;

  // Capacity register; the user must write it between commands only; the block itself does not enforce this.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= dqr_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      cap_reg <= cfg.data;
    end
  end

  // Read stage drains when the response register is free or being emptied.
  assign out_load  = pend && (!rsp.valid || rsp.ready);
  assign cmd.ready = !pend || out_load;
  assign cmd_fire  = cmd.valid && cmd.ready;

  dqr_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (cmd_fire),
    .opcode    (cmd.opcode),
    .cap_reg   (cap_reg),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .head_next (head_next),
    .tail_next (tail_next),
    .status    (status)
  );

  // Write of an insert and reads of the new front and rear share the accept cycle.
  dqr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (cmd.value_in),
    .rd_en     (cmd_fire),
    .rd_addr_a (head_next),
    .rd_addr_b (tail_next),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cmd_fire) begin
        pend <= 1'b1;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload; an empty queue reports -1 on both ends.
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.accepted    <= status.accepted;
      rsp.is_empty    <= status.is_empty;
      rsp.is_full     <= status.is_full;
      rsp.occupancy   <= status.occupancy;
      rsp.front_value <= status.is_empty ? dqr_pkg::EMPTY_VALUE : rd_front;
      rsp.rear_value  <= status.is_empty ? dqr_pkg::EMPTY_VALUE : rd_rear;
    end
  end

  a_cmd_pends: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> pend)
    else $error("accepted command did not reach the read stage");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (pend && !out_load && !cmd_fire) |=> (pend && $stable(status)))
    else $error("stalled read stage lost its command");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |->
      (rsp.front_value == -32'sd1 && rsp.rear_value == -32'sd1 && rsp.occupancy == '0))
    else $error("empty response with stale end values");

endmodule

// ===== tb/sv/double_ended_ring_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended ring queue.
module double_ended_ring_queue_test;

  localparam int DEPTH = 16;

  // Opcodes past OP_PEEK are reserved: no state change, accepted low.
  localparam logic [dqr_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [dqr_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  // Capacity register values worth hitting: zero acts as one, above DEPTH acts as DEPTH.
  localparam logic [dqr_pkg::CAP_W-1:0] CAP_ZERO = 5'd0;
  localparam logic [dqr_pkg::CAP_W-1:0] CAP_ONE  = 5'd1;
  localparam logic [dqr_pkg::CAP_W-1:0] CAP_FULL = 5'd16;
  localparam logic [dqr_pkg::CAP_W-1:0] CAP_MAX  = 5'd31;

  // Queue as seen in one response transaction.
  typedef struct {
    dqr_pkg::status_t           flags;
    logic [dqr_pkg::DATA_W-1:0] front_value;
    logic [dqr_pkg::DATA_W-1:0] rear_value;
  } deque_view_t;

  logic clk;
  logic rst;

  dqr_cmd_if cmd_ch ();
  dqr_rsp_if rsp_ch ();
  dqr_cfg_if cfg_ch ();

  double_ended_ring_queue #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the block state. Indices and count follow the same update rules
  // as the hardware, including an index left beyond a lowered capacity.
  // ---------------------------------------------------------------------------
  logic [dqr_pkg::DATA_W-1:0] ring_mirror [DEPTH];
  int                         head_idx;
  int                         tail_idx;
  int                         elem_count;
  logic [dqr_pkg::CAP_W-1:0]  cap_reg;

  deque_view_t pending_views [$];   // expected responses, oldest first

  int send_idle_pct;                // chance per cycle that the sender idles
  int recv_idle_pct;                // chance per cycle that rsp.ready is low
  int stall_request;                // long rsp hold-off asked by a test
  int stall_cycles_left;

  int mismatch_count;
  int items_sent;
  int results_checked;
  int cap_writes;

  // Clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int ring_next(int idx, int cap);
    return (idx >= cap - 1) ? 0 : idx + 1;
  endfunction

  function automatic int ring_prev(int idx, int cap);
    return (idx == 0) ? cap - 1 : idx - 1;
  endfunction

  // Applies one operation to the mirror, returns the response it should give.
  function automatic deque_view_t apply_deque_op(logic [dqr_pkg::OP_W-1:0] op,
                                                 logic [dqr_pkg::DATA_W-1:0] val);
    int          cap;
    bit          was_full;
    bit          was_empty;
    bit          ok;
    deque_view_t view;
    cap       = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    was_full  = elem_count >= cap;
    was_empty = elem_count == 0;
    ok        = 1'b0;
    case (op)
      dqr_pkg::OP_INS_FRONT: begin
        if (!was_full) begin
          head_idx = ring_prev(head_idx, cap);
          if (was_empty) tail_idx = head_idx;
          ring_mirror[head_idx] = val;
          elem_count++;
          ok = 1'b1;
        end
      end
      dqr_pkg::OP_INS_REAR: begin
        if (!was_full) begin
          tail_idx = ring_next(tail_idx, cap);
          if (was_empty) head_idx = tail_idx;
          ring_mirror[tail_idx] = val;
          elem_count++;
          ok = 1'b1;
        end
      end
      dqr_pkg::OP_DEL_FRONT: begin
        if (!was_empty) begin
          head_idx = ring_next(head_idx, cap);
          elem_count--;
          ok = 1'b1;
        end
      end
      dqr_pkg::OP_DEL_REAR: begin
        if (!was_empty) begin
          tail_idx = ring_prev(tail_idx, cap);
          elem_count--;
          ok = 1'b1;
        end
      end
      dqr_pkg::OP_PEEK: ok = 1'b1;
      default: ok = 1'b0;   // reserved opcode
    endcase
    view.flags.accepted  = ok;
    view.flags.is_empty  = (elem_count == 0);
    view.flags.is_full   = (elem_count >= cap);
    view.flags.occupancy = elem_count[dqr_pkg::CAP_W-1:0];
    view.front_value     = (elem_count == 0) ? dqr_pkg::EMPTY_VALUE : ring_mirror[head_idx];
    view.rear_value      = (elem_count == 0) ? dqr_pkg::EMPTY_VALUE : ring_mirror[tail_idx];
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One command transaction; the expectation is queued at the accepting edge.
  task automatic send_op(logic [dqr_pkg::OP_W-1:0] op, logic [dqr_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.value_in <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_views.push_back(apply_deque_op(op, val));
    items_sent++;
  endtask

  // Random operation; insert_pct steers the queue toward full or empty.
  task automatic send_random_op(int insert_pct);
    int                         r;
    logic [dqr_pkg::OP_W-1:0]   op;
    logic [dqr_pkg::DATA_W-1:0] val;
    r = $urandom_range(99);
    if (r < 4)
      op = dqr_pkg::OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
    else if (r < 12)
      op = dqr_pkg::OP_PEEK;
    else if ($urandom_range(99) < insert_pct)
      op = $urandom_range(1) ? dqr_pkg::OP_INS_FRONT : dqr_pkg::OP_INS_REAR;
    else
      op = $urandom_range(1) ? dqr_pkg::OP_DEL_FRONT : dqr_pkg::OP_DEL_REAR;
    case ($urandom_range(15))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'h0000_0000;
      3:       val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    send_op(op, val);
  endtask

  // Stop offering commands and wait for every outstanding response.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // Capacity write, only with nothing in flight.
  task automatic write_capacity(logic [dqr_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_reg = cap;
    cap_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [dqr_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0:       return CAP_ZERO;
      1:       return CAP_ONE;
      2:       return 5'd2;
      3:       return CAP_FULL;
      4:       return CAP_MAX;
      5:       return dqr_pkg::CAP_W'($urandom_range(30, 17));
      default: return dqr_pkg::CAP_W'($urandom_range(16, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: ready pattern plus an optional long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : drive_rsp_ready
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_cycles_left = stall_request;
        stall_request     = 0;
      end
      if (stall_cycles_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_cycles_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic compare_field(string name, logic [dqr_pkg::DATA_W-1:0] want,
                               logic [dqr_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  // Every response transaction is checked against the oldest expectation.
  always @(posedge clk) begin : check_responses
    deque_view_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_views.size() == 0) begin
        $error("response transaction with no command outstanding");
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        compare_field("accepted",    dqr_pkg::DATA_W'(want.flags.accepted),
                      dqr_pkg::DATA_W'(rsp_ch.accepted));
        compare_field("front_value", want.front_value, rsp_ch.front_value);
        compare_field("rear_value",  want.rear_value,  rsp_ch.rear_value);
        compare_field("is_empty",    dqr_pkg::DATA_W'(want.flags.is_empty),
                      dqr_pkg::DATA_W'(rsp_ch.is_empty));
        compare_field("is_full",     dqr_pkg::DATA_W'(want.flags.is_full),
                      dqr_pkg::DATA_W'(rsp_ch.is_full));
        compare_field("occupancy",   dqr_pkg::DATA_W'(want.flags.occupancy),
                      dqr_pkg::DATA_W'(rsp_ch.occupancy));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty queue right after reset: peek, refused removals, reserved opcodes.
  task automatic test_empty_queue();
    send_op(dqr_pkg::OP_PEEK, 32'h1234_5678);
    send_op(dqr_pkg::OP_DEL_FRONT, 32'h0);
    send_op(dqr_pkg::OP_DEL_REAR, 32'hFFFF_FFFF);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
      send_op(op[dqr_pkg::OP_W-1:0], $urandom);
  endtask

  // Fill at full capacity from both ends, then refused inserts.
  // This writes every ring entry, so later capacity changes never expose
  // an entry that was never written.
  task automatic test_fill_and_full();
    logic [dqr_pkg::DATA_W-1:0] extremes [4];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int k = 0; k < DEPTH; k++)
      send_op(k[0] ? dqr_pkg::OP_INS_FRONT : dqr_pkg::OP_INS_REAR,
              (k < 4) ? extremes[k] : $urandom);
    send_op(dqr_pkg::OP_INS_FRONT, 32'h5555_5555);
    send_op(dqr_pkg::OP_INS_REAR, 32'hAAAA_AAAA);
  endtask

  // Register extremes, written while the queue still holds elements, so the
  // capacity-below-count case and index wrap past a lowered capacity occur.
  task automatic test_capacity_extremes();
    logic [dqr_pkg::CAP_W-1:0] caps [4];
    caps = '{CAP_ZERO, CAP_MAX, CAP_ONE, CAP_FULL};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      for (int k = 0; k < 20; k++) send_random_op(k < 10 ? 30 : 70);
    end
  endtask

  // Random traffic in blocks, each under a fresh capacity; the insert bias
  // swings so the queue keeps hitting both empty and full.
  task automatic test_random_traffic(int n);
    int done;
    done = 0;
    while (done < n) begin
      write_capacity(pick_capacity());
      for (int k = 0; k < 40; k++) send_random_op(k < 20 ? 75 : 25);
      done += 40;
    end
  endtask

  // Long rsp hold-off while commands keep coming: cmd.ready must drop and
  // nothing may be lost or repeated.
  task automatic test_output_stall();
    write_capacity(CAP_FULL);
    stall_request = 80;
    for (int k = 0; k < 40; k++) send_random_op(60);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    cmd_ch.valid    <= 1'b0;
    cmd_ch.opcode   <= dqr_pkg::OP_PEEK;
    cmd_ch.value_in <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= dqr_pkg::CAP_RESET;
    rst             <= 1'b1;

    head_idx          = 0;
    tail_idx          = 0;
    elem_count        = 0;
    cap_reg           = dqr_pkg::CAP_RESET;
    stall_request     = 0;
    stall_cycles_left = 0;
    mismatch_count    = 0;
    items_sent        = 0;
    results_checked   = 0;
    cap_writes        = 0;
    foreach (ring_mirror[i]) ring_mirror[i] = '0;

    // Phase 1: sender rarely idles, receiver often stalls.
    send_idle_pct = 6;
    recv_idle_pct = 59;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_fill_and_full();
    test_capacity_extremes();
    test_random_traffic(120);

    // Phase 2: roles swapped.
    send_idle_pct = 59;
    recv_idle_pct = 6;
    test_random_traffic(160);

    // Phase 3: back to back, then the long stall.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(120);
    test_output_stall();

    // Drain, then keep watching for stray responses.
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Ran %0d command transactions, checked %0d responses, %0d capacity writes.",
             items_sent, results_checked, cap_writes);
    $display("Covered empty and full queue, reserved opcodes, capacity 0/1/16/31");
    $display("and a long rsp stall.");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
